// ===== rtl/core/npss_pkg.sv =====
// ----------------------------------------------------------------------------
// npss_pkg
// Shared widths, types and command codes for the nearest point on segment
// set core.
// ----------------------------------------------------------------------------
package npss_pkg;

  localparam int CW     = 32;            // coordinate width
  localparam int TFB    = 16;            // fraction bits of t
  localparam int MW     = CW + 1;        // coordinate difference width
  localparam int PW     = 2 * MW;        // product width
  localparam int DW     = PW + 2;        // accumulator width
  localparam int TW     = TFB + 1;       // clamped t width
  localparam int DSW    = 64;            // distance output width
  localparam int CNT_W  = $clog2(TFB);

  typedef enum logic [3:0] {
    ST_IDLE, ST_LEN0, ST_LEN1, ST_DOT0, ST_DOT1, ST_DOT2, ST_TSEL, ST_DIV,
    ST_PL0, ST_PL1, ST_PL2, ST_DS0, ST_DS1, ST_DS2, ST_UPD, ST_EMIT
  } state_t;

  typedef enum logic [2:0] {
    MS_DXDX, MS_DYDY, MS_UXDX, MS_UYDY, MS_DXT, MS_DYT, MS_EX, MS_EY
  } mul_sel_t;

  typedef enum logic [3:0] {
    AC_NONE, AC_LEN_LD, AC_LEN_ADD, AC_DOT_LD, AC_DOT_ADD,
    AC_CX, AC_CY, AC_DIST_LD, AC_DIST_ADD
  } acc_op_t;

  typedef struct packed {
    logic signed [CW-1:0] point_x;
    logic signed [CW-1:0] point_y;
    logic signed [CW-1:0] start_x;
    logic signed [CW-1:0] start_y;
    logic signed [CW-1:0] end_x;
    logic signed [CW-1:0] end_y;
    logic                 segment_present;
    logic                 first_segment;
    logic                 last_segment;
  } seg_t;

  typedef struct packed {
    logic     load;
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    logic     tsel;
    logic     div_step;
    logic     update;
    logic     emit;
  } cmd_t;

  typedef struct packed {
    logic need_div;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/core/npss_seg_if.sv =====
// ----------------------------------------------------------------------------
// npss_seg_if
// Segment input channel: valid/ready with one segment and query point.
// ----------------------------------------------------------------------------
interface npss_seg_if;
  import npss_pkg::*;

  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] point_x;
  logic signed [CW-1:0] point_y;
  logic signed [CW-1:0] start_x;
  logic signed [CW-1:0] start_y;
  logic signed [CW-1:0] end_x;
  logic signed [CW-1:0] end_y;
  logic                 segment_present;
  logic                 first_segment;
  logic                 last_segment;

  modport source (output valid, point_x, point_y, start_x, start_y, end_x, end_y,
                  segment_present, first_segment, last_segment, input ready);
  modport sink (input valid, point_x, point_y, start_x, start_y, end_x, end_y,
                segment_present, first_segment, last_segment, output ready);
endinterface

// ===== rtl/core/npss_res_if.sv =====
// ----------------------------------------------------------------------------
// npss_res_if
// Result channel: valid/ready with the nearest point of one set.
// ----------------------------------------------------------------------------
interface npss_res_if;
  import npss_pkg::*;

  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] closest_x;
  logic signed [CW-1:0] closest_y;
  logic [DSW-1:0]       best_distance_sq;
  logic                 found;

  modport source (output valid, closest_x, closest_y, best_distance_sq, found,
                  input ready);
  modport sink (input valid, closest_x, closest_y, best_distance_sq, found,
                output ready);
endinterface

// ===== rtl/core/npss_ctrl.sv =====
// ----------------------------------------------------------------------------
// npss_ctrl
// Sequencer: steps the shared multiplier, the t divider and the best update.
// ----------------------------------------------------------------------------
module npss_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_present,
  input  logic           in_last,
  output logic           in_ready,
  input  npss_pkg::sts_t sts,
  output npss_pkg::cmd_t cmd
);
  import npss_pkg::*;

  state_t           state_r, state_nxt;
  logic             last_r, last_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      last_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      last_r  <= last_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    last_nxt     = last_r;
    cnt_nxt      = cnt_r;
    in_ready     = 1'b0;
    cmd          = '0;
    cmd.mul_sel  = MS_DXDX;
    cmd.acc_op   = AC_NONE;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          last_nxt = in_last;
          if (in_present) state_nxt = ST_LEN0;
          else if (in_last) state_nxt = ST_EMIT;
        end
      end
      ST_LEN0: begin
        cmd.mul_sel = MS_DXDX;
        state_nxt   = ST_LEN1;
      end
      ST_LEN1: begin
        cmd.mul_sel = MS_DYDY;
        cmd.acc_op  = AC_LEN_LD;
        state_nxt   = ST_DOT0;
      end
      ST_DOT0: begin
        cmd.mul_sel = MS_UXDX;
        cmd.acc_op  = AC_LEN_ADD;
        state_nxt   = ST_DOT1;
      end
      ST_DOT1: begin
        cmd.mul_sel = MS_UYDY;
        cmd.acc_op  = AC_DOT_LD;
        state_nxt   = ST_DOT2;
      end
      ST_DOT2: begin
        cmd.acc_op = AC_DOT_ADD;
        state_nxt  = ST_TSEL;
      end
      ST_TSEL: begin
        cmd.tsel  = 1'b1;
        cnt_nxt   = '0;
        state_nxt = sts.need_div ? ST_DIV : ST_PL0;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(TFB - 1)) state_nxt = ST_PL0;
      end
      ST_PL0: begin
        cmd.mul_sel = MS_DXT;
        state_nxt   = ST_PL1;
      end
      ST_PL1: begin
        cmd.mul_sel = MS_DYT;
        cmd.acc_op  = AC_CX;
        state_nxt   = ST_PL2;
      end
      ST_PL2: begin
        cmd.acc_op = AC_CY;
        state_nxt  = ST_DS0;
      end
      ST_DS0: begin
        cmd.mul_sel = MS_EX;
        state_nxt   = ST_DS1;
      end
      ST_DS1: begin
        cmd.mul_sel = MS_EY;
        cmd.acc_op  = AC_DIST_LD;
        state_nxt   = ST_DS2;
      end
      ST_DS2: begin
        cmd.acc_op = AC_DIST_ADD;
        state_nxt  = ST_UPD;
      end
      ST_UPD: begin
        cmd.update = 1'b1;
        state_nxt  = last_r ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/core/npss_dp.sv =====
// ----------------------------------------------------------------------------
// npss_dp
// Datapath: operand registers, shared multiplier, t divider, running best
// and the result register.
// ----------------------------------------------------------------------------
module npss_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  npss_pkg::seg_t                 seg,
  input  npss_pkg::cmd_t                 cmd,
  output npss_pkg::sts_t                 sts,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [npss_pkg::CW-1:0] out_x,
  output logic signed [npss_pkg::CW-1:0] out_y,
  output logic [npss_pkg::DSW-1:0]       out_dist,
  output logic                           out_found
);
  import npss_pkg::*;

  logic signed [CW-1:0] px_r, py_r, sx_r, sy_r, cx_r, cy_r;
  logic signed [MW-1:0] dx_r, dy_r, ux_r, uy_r;
  logic [DW-1:0]        len_r, r_r;
  logic signed [DW-1:0] dot_r;
  logic [TW-1:0]        t_r;
  logic [PW-1:0]        prod_r;
  logic                 neg_r;
  logic [PW:0]          dist_r;
  logic signed [CW-1:0] best_x_r, best_y_r;
  logic [DSW-1:0]       best_dist_r;
  logic                 have_r;
  logic                 out_valid_r;
  logic signed [CW-1:0] out_x_r, out_y_r;
  logic [DSW-1:0]       out_dist_r;
  logic                 out_found_r;

  logic signed [MW-1:0] op_a, op_b, ex_w, ey_w;
  logic [MW-1:0]        mag_a, mag_b;
  logic signed [DW-1:0] prod_s;
  logic [PW:0]          place_sum;
  logic [MW-1:0]        q_w;
  logic signed [MW:0]   c_w;
  logic signed [CW-1:0] s_sel;
  logic [DW-1:0]        r2_w;
  logic [DSW-1:0]       dsat;

  assign ex_w = MW'(cx_r) - MW'(px_r);
  assign ey_w = MW'(cy_r) - MW'(py_r);

  always_comb begin
    case (cmd.mul_sel)
      MS_DXDX: begin op_a = dx_r; op_b = dx_r; end
      MS_DYDY: begin op_a = dy_r; op_b = dy_r; end
      MS_UXDX: begin op_a = ux_r; op_b = dx_r; end
      MS_UYDY: begin op_a = uy_r; op_b = dy_r; end
      MS_DXT:  begin op_a = dx_r; op_b = $signed(MW'(t_r)); end
      MS_DYT:  begin op_a = dy_r; op_b = $signed(MW'(t_r)); end
      MS_EX:   begin op_a = ex_w; op_b = ex_w; end
      MS_EY:   begin op_a = ey_w; op_b = ey_w; end
      default: begin op_a = '0; op_b = '0; end
    endcase
    mag_a = op_a[MW-1] ? MW'(-op_a) : MW'(op_a);
    mag_b = op_b[MW-1] ? MW'(-op_b) : MW'(op_b);
  end

  assign prod_s    = neg_r ? -$signed(DW'(prod_r)) : $signed(DW'(prod_r));
  assign place_sum = (PW + 1)'(prod_r) + (neg_r ? (PW + 1)'((1 << TFB) - 1) : '0);
  assign q_w       = MW'(place_sum >> TFB);
  assign s_sel     = (cmd.acc_op == AC_CX) ? sx_r : sy_r;
  assign c_w       = neg_r ? (MW + 1)'(s_sel) - $signed((MW + 1)'(q_w))
                           : (MW + 1)'(s_sel) + $signed((MW + 1)'(q_w));
  assign r2_w      = r_r << 1;
  assign dsat      = (|dist_r[PW:DSW]) ? '1 : dist_r[DSW-1:0];

  always_comb begin
    sts.need_div = 1'b0;
    if (len_r != '0 && dot_r > 0 && $unsigned(dot_r) < len_r) sts.need_div = 1'b1;
    sts.out_free = !out_valid_r || out_ready;
  end

  always_ff @(posedge clk) begin
    prod_r <= PW'(mag_a * mag_b);
    neg_r  <= op_a[MW-1] ^ op_b[MW-1];
    if (cmd.load) begin
      px_r <= seg.point_x;
      py_r <= seg.point_y;
      sx_r <= seg.start_x;
      sy_r <= seg.start_y;
      dx_r <= MW'(seg.end_x) - MW'(seg.start_x);
      dy_r <= MW'(seg.end_y) - MW'(seg.start_y);
      ux_r <= MW'(seg.point_x) - MW'(seg.start_x);
      uy_r <= MW'(seg.point_y) - MW'(seg.start_y);
    end
    case (cmd.acc_op)
      AC_LEN_LD:   len_r  <= DW'(prod_r);
      AC_LEN_ADD:  len_r  <= len_r + DW'(prod_r);
      AC_DOT_LD:   dot_r  <= prod_s;
      AC_DOT_ADD:  dot_r  <= dot_r + prod_s;
      AC_CX:       cx_r   <= c_w[CW-1:0];
      AC_CY:       cy_r   <= c_w[CW-1:0];
      AC_DIST_LD:  dist_r <= (PW + 1)'(prod_r);
      AC_DIST_ADD: dist_r <= dist_r + (PW + 1)'(prod_r);
      default: ;
    endcase
    if (cmd.tsel) begin
      r_r <= $unsigned(dot_r);
      if (len_r != '0 && dot_r > 0 && $unsigned(dot_r) >= len_r) t_r <= TW'(1 << TFB);
      else t_r <= '0;
    end else if (cmd.div_step) begin
      if (r2_w >= len_r) begin
        r_r <= r2_w - len_r;
        t_r <= {t_r[TW-2:0], 1'b1};
      end else begin
        r_r <= r2_w;
        t_r <= {t_r[TW-2:0], 1'b0};
      end
    end
    if (cmd.emit) begin
      out_x_r     <= best_x_r;
      out_y_r     <= best_y_r;
      out_dist_r  <= best_dist_r;
      out_found_r <= have_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_x_r    <= '0;
      best_y_r    <= '0;
      best_dist_r <= '1;
      have_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load && seg.first_segment) begin
        best_x_r    <= '0;
        best_y_r    <= '0;
        best_dist_r <= '1;
        have_r      <= 1'b0;
      end else if (cmd.update && (!have_r || dsat < best_dist_r)) begin
        best_x_r    <= cx_r;
        best_y_r    <= cy_r;
        best_dist_r <= dsat;
        have_r      <= 1'b1;
      end
      if (cmd.emit) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_x     = out_x_r;
  assign out_y     = out_y_r;
  assign out_dist  = out_dist_r;
  assign out_found = out_found_r;

endmodule

// ===== rtl/core/nearest_point_on_segment_set_core.sv =====
// ----------------------------------------------------------------------------
// nearest_point_on_segment_set_core
// Nearest point to a query over a set of 2D segments, Q16.16 fixed point.
//
//   channel   dir  handshake              payload
//   in_seg    in   valid/ready            point, start, end, set marks
//   out_res   out  valid/ready            closest point, distance, found
//
// A segment item runs 14 sequencer steps plus the radix-2 divider for t;
// when t clamps to 0 or 1 the divider is skipped. One shared 33x33
// multiplier carries every product.
// An item without a segment skips the sequencer; a last item adds the emit step to post a result.
// Reset is synchronous; the running best resets to no candidate.
// A waiting result is held in the output register while the next item runs;
// posting a further result stalls until that register is taken.
// ----------------------------------------------------------------------------
module nearest_point_on_segment_set_core (
  input  logic      clk,
  input  logic      rst_n,
  npss_seg_if.sink  in_seg,
  npss_res_if.source out_res
);
  import npss_pkg::*;

  seg_t seg;
  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  assign seg.point_x         = in_seg.point_x;
  assign seg.point_y         = in_seg.point_y;
  assign seg.start_x         = in_seg.start_x;
  assign seg.start_y         = in_seg.start_y;
  assign seg.end_x           = in_seg.end_x;
  assign seg.end_y           = in_seg.end_y;
  assign seg.segment_present = in_seg.segment_present;
  assign seg.first_segment   = in_seg.first_segment;
  assign seg.last_segment    = in_seg.last_segment;
  assign in_seg.ready        = in_ready;

  npss_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_seg.valid),
    .in_present (in_seg.segment_present),
    .in_last    (in_seg.last_segment),
    .in_ready   (in_ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  npss_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .seg       (seg),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_res.valid),
    .out_ready (out_res.ready),
    .out_x     (out_res.closest_x),
    .out_y     (out_res.closest_y),
    .out_dist  (out_res.best_distance_sq),
    .out_found (out_res.found)
  );

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Testbench for nearest_point_on_segment_set_core. Sends sets of segments
// with a query point, predicts the nearest point of each set in the
// testbench, and checks every result transfer field by field. Both sides
// idle in random bursts; the receiver holds off once for a long stretch and
// the sender once pauses until all results are in.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import npss_pkg::*;

  typedef struct {
    logic signed [CW-1:0] closest_x;
    logic signed [CW-1:0] closest_y;
    logic [DSW-1:0]       best_distance_sq;
    logic                 found;
  } nearest_t;

  localparam int NUM_ITEMS   = 1700;
  localparam int QUIET_TAIL  = 150;
  localparam int WATCH_LIMIT = 4000;
  localparam int LONG_HOLD   = 400;
  localparam int DRAIN_AT    = 900;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  npss_seg_if seg_if ();
  npss_res_if res_if ();

  nearest_point_on_segment_set_core i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_seg (seg_if),
    .out_res(res_if)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  seg_t     pending_q[$];
  nearest_t nearest_q[$];
  int       errors = 0;
  int       sent = 0;
  int       received = 0;
  int       in_gap = 0;
  int       out_gap = 0;
  bit       long_hold_done = 0;
  bit       tail_last = 0;
  bit       draining = 0;
  bit       drain_done = 0;
  int       watch = 0;

  logic signed [CW-1:0] run_x, run_y;
  logic [DSW-1:0]       run_dist;
  logic                 run_have;

  function automatic bit predict_nearest(input seg_t s, output nearest_t r);
    logic signed [127:0] px, py, sx, sy, dx, dy, len, dot, t, cx, cy, d;
    logic [DSW-1:0]      dsat;
    if (s.first_segment) begin
      run_x = '0; run_y = '0; run_dist = '1; run_have = 1'b0;
    end
    if (s.segment_present) begin
      px = s.point_x; py = s.point_y; sx = s.start_x; sy = s.start_y;
      dx = s.end_x;   dy = s.end_y;
      dx = dx - sx;   dy = dy - sy;
      len = dx * dx + dy * dy;
      cx = sx; cy = sy;
      if (len != 0) begin
        dot = (px - sx) * dx + (py - sy) * dy;
        t = 0;
        if (dot > 0) t = (dot >= len) ? (128'sd1 <<< TFB) : ((dot <<< TFB) / len);
        cx = sx + ((dx * t) >>> TFB);
        cy = sy + ((dy * t) >>> TFB);
      end
      d = (cx - px) * (cx - px) + (cy - py) * (cy - py);
      dsat = ((d >>> DSW) != 0) ? '1 : d[DSW-1:0];
      if (!run_have || dsat < run_dist) begin
        run_x = cx[CW-1:0]; run_y = cy[CW-1:0]; run_dist = dsat; run_have = 1'b1;
      end
    end
    r.closest_x = run_x;
    r.closest_y = run_y;
    r.best_distance_sq = run_dist;
    r.found = run_have;
    return s.last_segment;
  endfunction

  function automatic seg_t mk_seg(input logic [CW-1:0] px, py, sx, sy, ex, ey,
                                  input bit pres, first, last);
    seg_t s;
    s.point_x = px; s.point_y = py; s.start_x = sx; s.start_y = sy;
    s.end_x = ex; s.end_y = ey;
    s.segment_present = pres; s.first_segment = first; s.last_segment = last;
    return s;
  endfunction

  function automatic logic [CW-1:0] rand_coord(input int mode);
    case (mode)
      0:       return $urandom;
      1:       return $urandom_range(0, 32'h001F_FFFF) - 32'h0010_0000;
      2:       return $urandom_range(0, 32'h3FFF) - 32'h2000;
      default: return $urandom_range(0, 7) - 4;
    endcase
  endfunction

  // driver
  always @(posedge clk) begin
    seg_t     s;
    nearest_t r;
    if (!rst_n) begin
      seg_if.valid <= 1'b0;
    end else if (!seg_if.valid || seg_if.ready) begin
      if (seg_if.valid) sent++;
      if (!drain_done && sent >= DRAIN_AT && tail_last) draining = 1;
      if (draining && nearest_q.size() == 0) begin
        draining = 0;
        drain_done = 1;
      end
      if (in_gap > 0) begin
        in_gap--;
        seg_if.valid <= 1'b0;
      end else if (draining) begin
        seg_if.valid <= 1'b0;
      end else if (pending_q.size() != 0 &&
                   pending_q.size() > QUIET_TAIL && $urandom_range(0, 7) == 0) begin
        in_gap = $urandom_range(1, 4) - 1;
        seg_if.valid <= 1'b0;
      end else if (pending_q.size() != 0) begin
        s = pending_q.pop_front();
        tail_last = s.last_segment;
        if (predict_nearest(s, r)) nearest_q.push_back(r);
        seg_if.valid           <= 1'b1;
        seg_if.point_x         <= s.point_x;
        seg_if.point_y         <= s.point_y;
        seg_if.start_x         <= s.start_x;
        seg_if.start_y         <= s.start_y;
        seg_if.end_x           <= s.end_x;
        seg_if.end_y           <= s.end_y;
        seg_if.segment_present <= s.segment_present;
        seg_if.first_segment   <= s.first_segment;
        seg_if.last_segment    <= s.last_segment;
      end else begin
        seg_if.valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    nearest_t e;
    if (!rst_n) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        received++;
        if (nearest_q.size() == 0) begin
          $error("result transfer with no expectation waiting");
          errors++;
        end else begin
          e = nearest_q.pop_front();
          if (res_if.closest_x !== e.closest_x) begin
            $error("closest_x expected %0d actual %0d", e.closest_x, res_if.closest_x);
            errors++;
          end
          if (res_if.closest_y !== e.closest_y) begin
            $error("closest_y expected %0d actual %0d", e.closest_y, res_if.closest_y);
            errors++;
          end
          if (res_if.best_distance_sq !== e.best_distance_sq) begin
            $error("best_distance_sq expected %0h actual %0h",
                   e.best_distance_sq, res_if.best_distance_sq);
            errors++;
          end
          if (res_if.found !== e.found) begin
            $error("found expected %0b actual %0b", e.found, res_if.found);
            errors++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        res_if.ready <= 1'b0;
      end else if (!long_hold_done && received == 30) begin
        long_hold_done = 1;
        out_gap = LONG_HOLD;
        res_if.ready <= 1'b0;
      end else if (pending_q.size() > QUIET_TAIL && $urandom_range(0, 5) == 0) begin
        out_gap = $urandom_range(1, 4) - 1;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((seg_if.valid && seg_if.ready) || (res_if.valid && res_if.ready)) watch <= 0;
    else watch <= watch + 1;
    if (watch >= WATCH_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int       n, mode;
    bit       pres, first, last, noisy;
    logic [CW-1:0] px, py, sx, sy;
    seg_t     s;
    seg_if.valid = 1'b0;
    seg_if.point_x = '0; seg_if.point_y = '0;
    seg_if.start_x = '0; seg_if.start_y = '0;
    seg_if.end_x = '0;   seg_if.end_y = '0;
    seg_if.segment_present = 1'b0;
    seg_if.first_segment = 1'b0;
    seg_if.last_segment = 1'b0;
    res_if.ready = 1'b0;

    // saturated first candidate on a zero-length segment at the extremes
    pending_q.push_back(mk_seg(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                               32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1, 1, 1));
    // empty set
    pending_q.push_back(mk_seg('1, '1, '1, '1, '1, '1, 0, 1, 1));
    // tie keeps the earlier candidate, then an absent item closes the set
    pending_q.push_back(mk_seg(0, 32'h0001_0000, 32'hFFFF_0000, 0, 32'h0001_0000, 0, 1, 1, 0));
    pending_q.push_back(mk_seg(0, 32'h0001_0000, 32'h0001_0000, 0, 32'hFFFF_0000, 0, 1, 0, 0));
    pending_q.push_back(mk_seg(0, 0, 0, 0, 0, 0, 0, 0, 1));
    // no first mark: carry over from the emitted set
    pending_q.push_back(mk_seg(32'h0005_0000, 32'h0005_0000, 0, 0, 32'h0000_8000, 0, 1, 0, 1));
    // t below zero, above one, in the middle, and a closer later candidate
    pending_q.push_back(mk_seg(32'hFFF0_0000, 32'h0003_0000, 0, 0,
                               32'h0004_0000, 32'h0001_0000, 1, 1, 0));
    pending_q.push_back(mk_seg(32'h0100_0000, 32'hFFFF_0000, 0, 0,
                               32'h0004_0000, 32'h0001_0000, 1, 0, 0));
    pending_q.push_back(mk_seg(32'h0001_2345, 32'h0002_1111, 32'hFFFF_0000, 32'hFFFE_0000,
                               32'h0003_0000, 32'h0004_0000, 1, 0, 1));
    // extremes on full-range segments, negative directions
    pending_q.push_back(mk_seg(0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                               32'h8000_0000, 32'h8000_0000, 1, 1, 0));
    pending_q.push_back(mk_seg(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                               32'h7FFF_FFFF, 32'h8000_0000, 1, 0, 0));
    pending_q.push_back(mk_seg(32'h1234_5678, 32'h8765_4321, 32'h8000_0000, 32'h8000_0000,
                               32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 0, 1));
    pending_q.push_back(mk_seg('1, '1, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 1, 1, 1));
    pending_q.push_back(mk_seg(3, 7, 5, 5, 5, 5, 1, 1, 0));
    pending_q.push_back(mk_seg(3, 7, 5, 5, 5, 5, 1, 0, 0));
    pending_q.push_back(mk_seg(0, 0, 0, 0, 0, 0, 0, 1, 0));
    pending_q.push_back(mk_seg(0, 0, 0, 0, 0, 0, 0, 0, 1));

    while (pending_q.size() < NUM_ITEMS) begin
      noisy = ($urandom_range(0, 99) < 15);
      n = $urandom_range(1, 6);
      mode = $urandom_range(0, 3);
      px = rand_coord(mode);
      py = rand_coord(mode);
      for (int i = 0; i < n; i++) begin
        pres = ($urandom_range(0, 9) != 0);
        first = (i == 0);
        last = (i == n - 1);
        if (noisy) begin
          first = $urandom_range(0, 1);
          last = $urandom_range(0, 1);
        end
        sx = rand_coord(mode);
        sy = rand_coord(mode);
        s = mk_seg(px, py, sx, sy, rand_coord(mode), rand_coord(mode), pres, first, last);
        if ($urandom_range(0, 19) == 0) begin
          s.end_x = sx;
          s.end_y = sy;
        end
        pending_q.push_back(s);
      end
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_q.size() == 0 && !seg_if.valid && nearest_q.size() == 0);
    repeat (80) @(posedge clk);
    if (errors == 0 && nearest_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/npss_pkg.sv
rtl/core/npss_seg_if.sv
rtl/core/npss_res_if.sv
rtl/core/npss_ctrl.sv
rtl/core/npss_dp.sv
rtl/core/nearest_point_on_segment_set_core.sv
test/tb.sv
